// ===== src/sexpr_token_lexer_macros.svh =====
// Assertion macros shared by the lexer's checker.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SEXPR_TOKEN_LEXER_MACROS_SVH
`define SEXPR_TOKEN_LEXER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/stl_pkg.sv =====
// Shared types, constants and character-class functions of the S-expression lexer.
// No dependencies; the other files of the block that use it refer to it by scoped names.
package stl_pkg;

	localparam int LENGTH_WIDTH_DEF   = 12;
	localparam int POSITION_WIDTH_DEF = 16;
	localparam int KIND_WIDTH         = 5;
	localparam int QUEUE_DEPTH        = 4;

	typedef enum logic [KIND_WIDTH-1:0] {
		KIND_ERROR        = 5'd0,
		KIND_EOF          = 5'd1,
		KIND_LPAREN       = 5'd2,
		KIND_RPAREN       = 5'd3,
		KIND_INDEX        = 5'd4,
		KIND_ATTRIBUTE    = 5'd5,
		KIND_KEYWORD      = 5'd6,
		KIND_SYMBOL       = 5'd7,
		KIND_QSYM         = 5'd8,
		KIND_UNTERM_QSYM  = 5'd9,
		KIND_STRING       = 5'd10,
		KIND_UNTERM_STR   = 5'd11,
		KIND_INT          = 5'd12,
		KIND_DEC          = 5'd13,
		KIND_BIN          = 5'd14,
		KIND_HEX          = 5'd15,
		KIND_FIELD        = 5'd16
	} kind_t;

	typedef enum logic [19:0] {
		M_IDLE    = 20'h00001,
		M_COMMENT = 20'h00002,
		M_QSYM    = 20'h00004,
		M_STR     = 20'h00008,
		M_STR_Q   = 20'h00010,
		M_HASH    = 20'h00020,
		M_BIN0    = 20'h00040,
		M_BIN     = 20'h00080,
		M_HEX0    = 20'h00100,
		M_HEX     = 20'h00200,
		M_FF0     = 20'h00400,
		M_FFA     = 20'h00800,
		M_FFM     = 20'h01000,
		M_FFB     = 20'h02000,
		M_INT     = 20'h04000,
		M_DEC0    = 20'h08000,
		M_DEC     = 20'h10000,
		M_COLON   = 20'h20000,
		M_KEYWORD = 20'h40000,
		M_SYMBOL  = 20'h80000
	} mode_t;

	// Which of the two result slots a character fills.
	typedef struct packed {
		logic first;
		logic second;
	} push_t;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SEMI  = ";";
	localparam logic [7:0] CH_BAR   = "|";
	localparam logic [7:0] CH_HASH  = "#";
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COLON = ":";
	localparam logic [7:0] CH_LPAR  = "(";
	localparam logic [7:0] CH_RPAR  = ")";
	localparam logic [7:0] CH_UNDER = "_";
	localparam logic [7:0] CH_BANG  = "!";
	localparam logic [7:0] CH_M     = "m";
	localparam logic [7:0] CH_DOT   = ".";
	localparam logic [7:0] CH_B     = "b";
	localparam logic [7:0] CH_X     = "x";
	localparam logic [7:0] CH_F     = "f";

	function automatic logic is_space(input logic [7:0] c);
		return (c == " ") || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_bit(input logic [7:0] c);
		return c == "0" || c == "1";
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic is_sym_start(input logic [7:0] c);
		logic r;
		r = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		case (c)
			"~", "!", "@", "$", "%", "^", "&", "*", "+", "=",
			"<", ">", ".", "?", "/", "_", "-": r = 1'b1;
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic is_sym_char(input logic [7:0] c);
		return is_sym_start(c) || is_digit(c);
	endfunction

endpackage

// ===== src/stl_in_if.sv =====
// Character channel of the lexer: one byte or an end-of-input mark per word.
// Depends on nothing.
interface stl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_input;

	modport source (output valid, output char_byte, output end_of_input, input ready);
	modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

// ===== src/stl_out_if.sv =====
// Token channel of the lexer: kind, length and start position per word.
// Depends on stl_pkg for the kind width.
interface stl_out_if #(
	parameter int LENGTH_WIDTH   = stl_pkg::LENGTH_WIDTH_DEF,
	parameter int POSITION_WIDTH = stl_pkg::POSITION_WIDTH_DEF
);
	logic                           valid;
	logic                           ready;
	logic [stl_pkg::KIND_WIDTH-1:0] token_kind;
	logic [LENGTH_WIDTH-1:0]        token_length;
	logic [POSITION_WIDTH-1:0]      start_line;
	logic [POSITION_WIDTH-1:0]      start_column;
	logic                           last;

	modport source (output valid, output token_kind, output token_length, output start_line,
		output start_column, output last, input ready);
	modport sink (input valid, input token_kind, input token_length, input start_line,
		input start_column, input last, output ready);
endinterface

// ===== src/stl_step.sv =====
// Next-state and result logic of the lexer for one character or end-of-input mark.
// Depends on stl_pkg for scan modes, token kinds and character classes.
module stl_step #(
	parameter int LENGTH_WIDTH   = stl_pkg::LENGTH_WIDTH_DEF,
	parameter int POSITION_WIDTH = stl_pkg::POSITION_WIDTH_DEF,
	localparam int EntryW        = stl_pkg::KIND_WIDTH + LENGTH_WIDTH + 2 * POSITION_WIDTH + 1
) (
	input  stl_pkg::mode_t              mode_q,
	input  logic [LENGTH_WIDTH-1:0]     len_q,
	input  logic [POSITION_WIDTH-1:0]   line_q,
	input  logic [POSITION_WIDTH-1:0]   col_q,
	input  logic [POSITION_WIDTH-1:0]   sline_q,
	input  logic [POSITION_WIDTH-1:0]   scol_q,
	input  logic [7:0]                  ch,
	input  logic                        eoi,
	output stl_pkg::mode_t              nxt_mode,
	output logic [LENGTH_WIDTH-1:0]     nxt_len,
	output logic [POSITION_WIDTH-1:0]   nxt_line,
	output logic [POSITION_WIDTH-1:0]   nxt_col,
	output logic [POSITION_WIDTH-1:0]   nxt_sline,
	output logic [POSITION_WIDTH-1:0]   nxt_scol,
	output stl_pkg::push_t              push,
	output logic [EntryW-1:0]           d0,
	output logic [EntryW-1:0]           d1
);

	logic [LENGTH_WIDTH-1:0] grow;
	logic                    a_v;
	stl_pkg::kind_t          a_kind;
	logic [LENGTH_WIDTH-1:0] a_len;
	logic                    b_v;
	stl_pkg::kind_t          b_kind;
	logic [LENGTH_WIDTH-1:0] b_len;
	logic                    relex;

	assign grow = (len_q == '1) ? len_q : len_q + LENGTH_WIDTH'(1);

	always_comb begin
		nxt_mode  = mode_q;
		nxt_len   = len_q;
		nxt_sline = sline_q;
		nxt_scol  = scol_q;
		nxt_line  = line_q;
		nxt_col   = col_q;
		a_v       = 1'b0;
		a_kind    = stl_pkg::KIND_ERROR;
		a_len     = len_q;
		b_v       = 1'b0;
		b_kind    = stl_pkg::KIND_ERROR;
		b_len     = LENGTH_WIDTH'(1);
		relex     = 1'b0;

		if (eoi) begin
			// Close whatever is open, then report end of stream at the current position.
			a_v = !(mode_q == stl_pkg::M_IDLE || mode_q == stl_pkg::M_COMMENT);
			case (mode_q)
				stl_pkg::M_QSYM:    a_kind = stl_pkg::KIND_UNTERM_QSYM;
				stl_pkg::M_STR:     a_kind = stl_pkg::KIND_UNTERM_STR;
				stl_pkg::M_STR_Q:   a_kind = stl_pkg::KIND_STRING;
				stl_pkg::M_SYMBOL:  a_kind = stl_pkg::KIND_SYMBOL;
				stl_pkg::M_KEYWORD: a_kind = stl_pkg::KIND_KEYWORD;
				stl_pkg::M_INT:     a_kind = stl_pkg::KIND_INT;
				stl_pkg::M_DEC:     a_kind = stl_pkg::KIND_DEC;
				stl_pkg::M_BIN:     a_kind = stl_pkg::KIND_BIN;
				stl_pkg::M_HEX:     a_kind = stl_pkg::KIND_HEX;
				stl_pkg::M_FFB:     a_kind = stl_pkg::KIND_FIELD;
				default:            a_kind = stl_pkg::KIND_ERROR;
			endcase
			b_v      = 1'b1;
			b_kind   = stl_pkg::KIND_EOF;
			b_len    = '0;
			nxt_mode = stl_pkg::M_IDLE;
			nxt_len  = '0;
		end else begin
			case (mode_q)
				stl_pkg::M_COMMENT: begin
					if (ch == stl_pkg::CH_LF) nxt_mode = stl_pkg::M_IDLE;
				end
				stl_pkg::M_QSYM: begin
					nxt_len = grow;
					if (ch == stl_pkg::CH_BAR) begin
						a_v = 1'b1; a_kind = stl_pkg::KIND_QSYM; a_len = grow;
						nxt_mode = stl_pkg::M_IDLE;
					end
				end
				stl_pkg::M_STR: begin
					nxt_len = grow;
					if (ch == stl_pkg::CH_QUOTE) nxt_mode = stl_pkg::M_STR_Q;
				end
				stl_pkg::M_STR_Q: begin
					// A doubled quote is an escaped quote inside the string.
					if (ch == stl_pkg::CH_QUOTE) begin
						nxt_len = grow; nxt_mode = stl_pkg::M_STR;
					end else begin
						a_v = 1'b1; a_kind = stl_pkg::KIND_STRING; relex = 1'b1;
					end
				end
				stl_pkg::M_HASH: begin
					if (ch == stl_pkg::CH_B) begin
						nxt_len = grow; nxt_mode = stl_pkg::M_BIN0;
					end else if (ch == stl_pkg::CH_X) begin
						nxt_len = grow; nxt_mode = stl_pkg::M_HEX0;
					end else if (ch == stl_pkg::CH_F) begin
						nxt_len = grow; nxt_mode = stl_pkg::M_FF0;
					end else begin
						a_v = 1'b1; a_len = grow; nxt_mode = stl_pkg::M_IDLE;
					end
				end
				stl_pkg::M_BIN0: begin
					if (stl_pkg::is_bit(ch)) begin
						nxt_len = grow; nxt_mode = stl_pkg::M_BIN;
					end else begin
						a_v = 1'b1; a_len = grow; nxt_mode = stl_pkg::M_IDLE;
					end
				end
				stl_pkg::M_BIN: begin
					if (stl_pkg::is_bit(ch)) nxt_len = grow;
					else begin
						a_v = 1'b1; a_kind = stl_pkg::KIND_BIN; relex = 1'b1;
					end
				end
				stl_pkg::M_HEX0: begin
					if (stl_pkg::is_hex(ch)) begin
						nxt_len = grow; nxt_mode = stl_pkg::M_HEX;
					end else begin
						a_v = 1'b1; a_len = grow; nxt_mode = stl_pkg::M_IDLE;
					end
				end
				stl_pkg::M_HEX: begin
					if (stl_pkg::is_hex(ch)) nxt_len = grow;
					else begin
						a_v = 1'b1; a_kind = stl_pkg::KIND_HEX; relex = 1'b1;
					end
				end
				stl_pkg::M_FF0: begin
					if (stl_pkg::is_digit(ch)) begin
						nxt_len = grow; nxt_mode = stl_pkg::M_FFA;
					end else begin
						a_v = 1'b1; a_len = grow; nxt_mode = stl_pkg::M_IDLE;
					end
				end
				stl_pkg::M_FFA: begin
					if (stl_pkg::is_digit(ch)) nxt_len = grow;
					else if (ch == stl_pkg::CH_M) begin
						nxt_len = grow; nxt_mode = stl_pkg::M_FFM;
					end else begin
						a_v = 1'b1; a_len = grow; nxt_mode = stl_pkg::M_IDLE;
					end
				end
				stl_pkg::M_FFM: begin
					if (stl_pkg::is_digit(ch)) begin
						nxt_len = grow; nxt_mode = stl_pkg::M_FFB;
					end else begin
						a_v = 1'b1; a_len = grow; nxt_mode = stl_pkg::M_IDLE;
					end
				end
				stl_pkg::M_FFB: begin
					if (stl_pkg::is_digit(ch)) nxt_len = grow;
					else begin
						a_v = 1'b1; a_kind = stl_pkg::KIND_FIELD; relex = 1'b1;
					end
				end
				stl_pkg::M_INT: begin
					if (stl_pkg::is_digit(ch)) nxt_len = grow;
					else if (ch == stl_pkg::CH_DOT) begin
						nxt_len = grow; nxt_mode = stl_pkg::M_DEC0;
					end else begin
						a_v = 1'b1; a_kind = stl_pkg::KIND_INT; relex = 1'b1;
					end
				end
				stl_pkg::M_DEC0: begin
					if (stl_pkg::is_digit(ch)) begin
						nxt_len = grow; nxt_mode = stl_pkg::M_DEC;
					end else begin
						a_v = 1'b1; a_len = grow; nxt_mode = stl_pkg::M_IDLE;
					end
				end
				stl_pkg::M_DEC: begin
					if (stl_pkg::is_digit(ch)) nxt_len = grow;
					else begin
						a_v = 1'b1; a_kind = stl_pkg::KIND_DEC; relex = 1'b1;
					end
				end
				stl_pkg::M_COLON: begin
					if (stl_pkg::is_sym_start(ch)) begin
						nxt_len = grow; nxt_mode = stl_pkg::M_KEYWORD;
					end else begin
						a_v = 1'b1; a_len = grow; nxt_mode = stl_pkg::M_IDLE;
					end
				end
				stl_pkg::M_KEYWORD: begin
					if (stl_pkg::is_sym_char(ch)) nxt_len = grow;
					else begin
						a_v = 1'b1; a_kind = stl_pkg::KIND_KEYWORD; relex = 1'b1;
					end
				end
				stl_pkg::M_SYMBOL: begin
					if (stl_pkg::is_sym_char(ch)) nxt_len = grow;
					else begin
						a_v = 1'b1; a_kind = stl_pkg::KIND_SYMBOL; relex = 1'b1;
					end
				end
				default: relex = 1'b1;
			endcase

			// The character that ended a token, or one seen between tokens, may start a new one.
			if (relex) begin
				nxt_mode = stl_pkg::M_IDLE;
				if (!stl_pkg::is_space(ch)) begin
					case (ch)
						stl_pkg::CH_SEMI:  nxt_mode = stl_pkg::M_COMMENT;
						stl_pkg::CH_BAR:   nxt_mode = stl_pkg::M_QSYM;
						stl_pkg::CH_QUOTE: nxt_mode = stl_pkg::M_STR;
						stl_pkg::CH_HASH:  nxt_mode = stl_pkg::M_HASH;
						stl_pkg::CH_COLON: nxt_mode = stl_pkg::M_COLON;
						stl_pkg::CH_LPAR:  begin b_v = 1'b1; b_kind = stl_pkg::KIND_LPAREN;    end
						stl_pkg::CH_RPAR:  begin b_v = 1'b1; b_kind = stl_pkg::KIND_RPAREN;    end
						stl_pkg::CH_UNDER: begin b_v = 1'b1; b_kind = stl_pkg::KIND_INDEX;     end
						stl_pkg::CH_BANG:  begin b_v = 1'b1; b_kind = stl_pkg::KIND_ATTRIBUTE; end
						default: begin
							if (stl_pkg::is_digit(ch)) nxt_mode = stl_pkg::M_INT;
							else if (stl_pkg::is_sym_start(ch)) nxt_mode = stl_pkg::M_SYMBOL;
							else b_v = 1'b1;
						end
					endcase
					if (nxt_mode != stl_pkg::M_IDLE && nxt_mode != stl_pkg::M_COMMENT) begin
						nxt_len   = LENGTH_WIDTH'(1);
						nxt_sline = line_q;
						nxt_scol  = col_q;
					end
				end
			end

			if (ch == stl_pkg::CH_LF) begin
				nxt_line = (line_q == '1) ? line_q : line_q + POSITION_WIDTH'(1);
				nxt_col  = '0;
			end else begin
				nxt_col = (col_q == '1) ? col_q : col_q + POSITION_WIDTH'(1);
			end
		end
	end

	// Results are packed as {kind, length, line, column, last}; the first valid one goes to d0.
	always_comb begin
		push.first  = a_v || b_v;
		push.second = a_v && b_v;
		d1 = {b_kind, b_len, line_q, col_q, 1'b1};
		if (a_v) d0 = {a_kind, a_len, sline_q, scol_q, !b_v};
		else     d0 = d1;
	end

endmodule

// ===== src/stl_queue.sv =====
// Small result queue of the lexer: takes up to two words a cycle, gives one while the consumer is ready.
// Depends on stl_pkg for the push flags.
module stl_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = stl_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  stl_pkg::push_t    push,
	input  logic [WIDTH-1:0]  d0,
	input  logic [WIDTH-1:0]  d1,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WIDTH-1:0]  out_data
);

	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_q;
	logic [PtrW-1:0]  rd_q;
	logic [CntW-1:0]  cnt_q;
	logic             pop;
	logic [PtrW-1:0]  wr_next;

	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_q];
	// Room is judged on space for two words, so it does not wait on the consumer.
	assign room      = cnt_q <= CntW'(DEPTH - 2);
	assign wr_next   = wr_q + PtrW'(1);

	always_ff @(posedge clk) begin
		if (push.first) mem_q[wr_q] <= d0;
		if (push.second) mem_q[wr_next] <= d1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PtrW'(push.first) + PtrW'(push.second);
			if (pop) rd_q <= rd_q + PtrW'(1);
			cnt_q <= cnt_q + CntW'(push.first) + CntW'(push.second) - CntW'(pop);
		end
	end

endmodule

// ===== src/sexpr_token_lexer.sv =====
// S-expression token lexer. Characters enter one per word; each word is registered, classified
// against the scan state, and its tokens land in a four-entry result queue. The sustained rate
// is one character per cycle; a character that both closes a token and yields another (or an
// end-of-input mark after an open token) gives two token words, which leave the queue at one
// word per cycle while the consumer is ready, so input holds off only while the queue cannot
// take two words. A character is first held in the stage register; its tokens are written into
// the queue when it is processed and are offered at the output from then on.
// Depends on stl_pkg, stl_in_if, stl_out_if, stl_step and stl_queue.
module sexpr_token_lexer #(
	parameter int LENGTH_WIDTH   = stl_pkg::LENGTH_WIDTH_DEF,
	parameter int POSITION_WIDTH = stl_pkg::POSITION_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	stl_in_if.sink     chars,
	stl_out_if.source  tokens
);

	localparam int EntryW = stl_pkg::KIND_WIDTH + LENGTH_WIDTH + 2 * POSITION_WIDTH + 1;

	logic                      valid_s1;
	logic [7:0]                char_s1;
	logic                      eoi_s1;
	logic                      room;
	logic                      go;

	stl_pkg::mode_t            mode_q;
	logic [LENGTH_WIDTH-1:0]   len_q;
	logic [POSITION_WIDTH-1:0] line_q;
	logic [POSITION_WIDTH-1:0] col_q;
	logic [POSITION_WIDTH-1:0] sline_q;
	logic [POSITION_WIDTH-1:0] scol_q;

	stl_pkg::mode_t            nxt_mode;
	logic [LENGTH_WIDTH-1:0]   nxt_len;
	logic [POSITION_WIDTH-1:0] nxt_line;
	logic [POSITION_WIDTH-1:0] nxt_col;
	logic [POSITION_WIDTH-1:0] nxt_sline;
	logic [POSITION_WIDTH-1:0] nxt_scol;
	stl_pkg::push_t            step_push;
	stl_pkg::push_t            push;
	logic [EntryW-1:0]         d0;
	logic [EntryW-1:0]         d1;
	logic [EntryW-1:0]         out_data;

	assign go           = valid_s1 && room;
	assign chars.ready  = !valid_s1 || go;
	assign push.first   = go && step_push.first;
	assign push.second  = go && step_push.second;

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_byte;
			eoi_s1  <= chars.end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= stl_pkg::M_IDLE;
			len_q    <= '0;
			line_q   <= '0;
			col_q    <= '0;
			sline_q  <= '0;
			scol_q   <= '0;
		end else begin
			if (chars.ready) valid_s1 <= chars.valid;
			if (go) begin
				mode_q  <= nxt_mode;
				len_q   <= nxt_len;
				line_q  <= nxt_line;
				col_q   <= nxt_col;
				sline_q <= nxt_sline;
				scol_q  <= nxt_scol;
			end
		end
	end

	stl_step #(
		.LENGTH_WIDTH   (LENGTH_WIDTH),
		.POSITION_WIDTH (POSITION_WIDTH)
	) u_step (
		.mode_q    (mode_q),
		.len_q     (len_q),
		.line_q    (line_q),
		.col_q     (col_q),
		.sline_q   (sline_q),
		.scol_q    (scol_q),
		.ch        (char_s1),
		.eoi       (eoi_s1),
		.nxt_mode  (nxt_mode),
		.nxt_len   (nxt_len),
		.nxt_line  (nxt_line),
		.nxt_col   (nxt_col),
		.nxt_sline (nxt_sline),
		.nxt_scol  (nxt_scol),
		.push      (step_push),
		.d0        (d0),
		.d1        (d1)
	);

	stl_queue #(
		.WIDTH (EntryW),
		.DEPTH (stl_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.d0        (d0),
		.d1        (d1),
		.room      (room),
		.out_valid (tokens.valid),
		.out_ready (tokens.ready),
		.out_data  (out_data)
	);

	assign {tokens.token_kind, tokens.token_length, tokens.start_line, tokens.start_column,
		tokens.last} = out_data;

endmodule

// ===== src/stl_checker.sv =====
// Port-level checks of the S-expression lexer, attached to the top level by bind.
// Depends on stl_pkg and the macros in sexpr_token_lexer_macros.svh.
`include "sexpr_token_lexer_macros.svh"

module stl_checker #(
	parameter int LENGTH_WIDTH   = stl_pkg::LENGTH_WIDTH_DEF,
	parameter int POSITION_WIDTH = stl_pkg::POSITION_WIDTH_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           tok_valid,
	input logic                           tok_ready,
	input logic [stl_pkg::KIND_WIDTH-1:0] tok_kind,
	input logic [LENGTH_WIDTH-1:0]        tok_length,
	input logic [POSITION_WIDTH-1:0]      tok_line,
	input logic [POSITION_WIDTH-1:0]      tok_column,
	input logic                           tok_last
);

	// A stalled token word keeps its contents.
	`STL_ASSERT_NEXT(a_hold, tok_valid && !tok_ready, tok_valid && $stable(tok_kind) && $stable(tok_length) && $stable(tok_line) && $stable(tok_column) && $stable(tok_last), "token word changed while stalled")

	// The end-of-stream word is always the final word of its character and is empty.
	`STL_ASSERT_IMP(a_eof, tok_valid && tok_kind == stl_pkg::KIND_EOF, tok_last && tok_length == '0, "eof word not last or not empty")

	// Both words of one character are queued together, so the second follows at once.
	`STL_ASSERT_NEXT(a_pair, tok_valid && tok_ready && !tok_last, tok_valid, "second word of a pair missing")

	// Only kinds up to the finite-field literal exist.
	`STL_ASSERT_IMP(a_kind, tok_valid, tok_kind <= stl_pkg::KIND_FIELD, "token kind out of range")

endmodule

bind sexpr_token_lexer stl_checker #(
	.LENGTH_WIDTH   (LENGTH_WIDTH),
	.POSITION_WIDTH (POSITION_WIDTH)
) u_stl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tok_valid  (tokens.valid),
	.tok_ready  (tokens.ready),
	.tok_kind   (tokens.token_kind),
	.tok_length (tokens.token_length),
	.tok_line   (tokens.start_line),
	.tok_column (tokens.start_column),
	.tok_last   (tokens.last)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for sexpr_token_lexer: random and directed character streams in,
// token words checked against a cycle-free predictor of the scan state kept in a class.
// Depends on stl_pkg, stl_in_if, stl_out_if and the lexer RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LW              = stl_pkg::LENGTH_WIDTH_DEF;
	localparam int PW              = stl_pkg::POSITION_WIDTH_DEF;
	localparam int STALL_LIMIT     = 5000;
	localparam int HOLD_CYCLES     = 80;
	localparam int MISMATCH_PRINTS = 60;
	localparam int RANDOM_WORDS    = 370;

	localparam string SYM_FIRST =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ~!@$%^&*+=<>.?/_-";
	localparam string SYM_REST =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789~!@$%^&*+=<>.?/_-";
	localparam string DIGITS  = "0123456789";
	localparam string HEXDIG  = "0123456789abcdefABCDEF";

	typedef struct packed {
		stl_pkg::kind_t  kind;
		logic [LW-1:0]   len;
		logic [PW-1:0]   line;
		logic [PW-1:0]   col;
		logic            last;
	} token_t;

	// Tracks the scan state and holds the tokens the lexer still owes.
	class token_predictor;
		stl_pkg::mode_t mode     = stl_pkg::M_IDLE;
		logic [LW-1:0]  len_cnt  = '0;
		logic [PW-1:0]  line_cnt = '0;
		logic [PW-1:0]  col_cnt  = '0;
		logic [PW-1:0]  tok_line = '0;
		logic [PW-1:0]  tok_col  = '0;
		token_t         pending_tokens[$];
		token_t         fresh[$];
		int unsigned    mismatches     = 0;
		int unsigned    tokens_checked = 0;
		logic [16:0]    kinds_seen     = '0;

		function bit in_text(string set, logic [7:0] ch);
			for (int i = 0; i < set.len(); i++)
				if (set[i] == ch)
					return 1'b1;
			return 1'b0;
		endfunction

		function bit is_blank(logic [7:0] ch);
			return ch == 8'd32 || (ch >= 8'd9 && ch <= 8'd13);
		endfunction

		function bit is_numeral(logic [7:0] ch);
			return ch >= "0" && ch <= "9";
		endfunction

		function logic [LW-1:0] bump_len(logic [LW-1:0] v);
			return (&v) ? v : v + 1'b1;
		endfunction

		function logic [PW-1:0] bump_pos(logic [PW-1:0] v);
			return (&v) ? v : v + 1'b1;
		endfunction

		function void grow();
			len_cnt = bump_len(len_cnt);
		endfunction

		function void put(stl_pkg::kind_t k, logic [LW-1:0] l, logic [PW-1:0] ln,
			logic [PW-1:0] c);
			token_t t;
			t.kind = k;
			t.len  = l;
			t.line = ln;
			t.col  = c;
			t.last = 1'b0;
			fresh = {fresh, t};
		endfunction

		function void close_as(stl_pkg::kind_t k);
			put(k, len_cnt, tok_line, tok_col);
			mode = stl_pkg::M_IDLE;
		endfunction

		// The offending byte counts toward the error token's length.
		function void close_bad();
			put(stl_pkg::KIND_ERROR, bump_len(len_cnt), tok_line, tok_col);
			mode = stl_pkg::M_IDLE;
		endfunction

		function void open_as(stl_pkg::mode_t m);
			mode     = m;
			len_cnt  = LW'(1);
			tok_line = line_cnt;
			tok_col  = col_cnt;
		endfunction

		function void lex_start(logic [7:0] ch);
			if (is_blank(ch))
				return;
			case (ch)
				stl_pkg::CH_SEMI:  mode = stl_pkg::M_COMMENT;
				stl_pkg::CH_BAR:   open_as(stl_pkg::M_QSYM);
				stl_pkg::CH_QUOTE: open_as(stl_pkg::M_STR);
				stl_pkg::CH_HASH:  open_as(stl_pkg::M_HASH);
				stl_pkg::CH_COLON: open_as(stl_pkg::M_COLON);
				stl_pkg::CH_LPAR:  put(stl_pkg::KIND_LPAREN, LW'(1), line_cnt, col_cnt);
				stl_pkg::CH_RPAR:  put(stl_pkg::KIND_RPAREN, LW'(1), line_cnt, col_cnt);
				stl_pkg::CH_UNDER: put(stl_pkg::KIND_INDEX, LW'(1), line_cnt, col_cnt);
				stl_pkg::CH_BANG:  put(stl_pkg::KIND_ATTRIBUTE, LW'(1), line_cnt, col_cnt);
				default: begin
					if (is_numeral(ch))
						open_as(stl_pkg::M_INT);
					else if (in_text(SYM_FIRST, ch))
						open_as(stl_pkg::M_SYMBOL);
					else
						put(stl_pkg::KIND_ERROR, LW'(1), line_cnt, col_cnt);
				end
			endcase
		endfunction

		function void note_char(logic [7:0] ch, logic eoi);
			bit relex;
			relex = 1'b0;
			fresh.delete();
			if (eoi) begin
				case (mode)
					stl_pkg::M_IDLE, stl_pkg::M_COMMENT: ;
					stl_pkg::M_QSYM:    close_as(stl_pkg::KIND_UNTERM_QSYM);
					stl_pkg::M_STR:     close_as(stl_pkg::KIND_UNTERM_STR);
					stl_pkg::M_STR_Q:   close_as(stl_pkg::KIND_STRING);
					stl_pkg::M_SYMBOL:  close_as(stl_pkg::KIND_SYMBOL);
					stl_pkg::M_KEYWORD: close_as(stl_pkg::KIND_KEYWORD);
					stl_pkg::M_INT:     close_as(stl_pkg::KIND_INT);
					stl_pkg::M_DEC:     close_as(stl_pkg::KIND_DEC);
					stl_pkg::M_BIN:     close_as(stl_pkg::KIND_BIN);
					stl_pkg::M_HEX:     close_as(stl_pkg::KIND_HEX);
					stl_pkg::M_FFB:     close_as(stl_pkg::KIND_FIELD);
					default:            close_as(stl_pkg::KIND_ERROR);
				endcase
				put(stl_pkg::KIND_EOF, '0, line_cnt, col_cnt);
				mode    = stl_pkg::M_IDLE;
				len_cnt = '0;
			end else begin
				case (mode)
					stl_pkg::M_COMMENT: if (ch == stl_pkg::CH_LF) mode = stl_pkg::M_IDLE;
					stl_pkg::M_QSYM: begin
						grow();
						if (ch == stl_pkg::CH_BAR)
							close_as(stl_pkg::KIND_QSYM);
					end
					stl_pkg::M_STR: begin
						grow();
						if (ch == stl_pkg::CH_QUOTE)
							mode = stl_pkg::M_STR_Q;
					end
					// A second quote right after a closing one is an escaped quote.
					stl_pkg::M_STR_Q: begin
						if (ch == stl_pkg::CH_QUOTE) begin
							grow();
							mode = stl_pkg::M_STR;
						end else begin
							close_as(stl_pkg::KIND_STRING);
							relex = 1'b1;
						end
					end
					stl_pkg::M_HASH: begin
						if (ch == stl_pkg::CH_B) begin
							grow();
							mode = stl_pkg::M_BIN0;
						end else if (ch == stl_pkg::CH_X) begin
							grow();
							mode = stl_pkg::M_HEX0;
						end else if (ch == stl_pkg::CH_F) begin
							grow();
							mode = stl_pkg::M_FF0;
						end else
							close_bad();
					end
					stl_pkg::M_BIN0: begin
						if (ch == "0" || ch == "1") begin
							grow();
							mode = stl_pkg::M_BIN;
						end else
							close_bad();
					end
					stl_pkg::M_BIN: begin
						if (ch == "0" || ch == "1")
							grow();
						else begin
							close_as(stl_pkg::KIND_BIN);
							relex = 1'b1;
						end
					end
					stl_pkg::M_HEX0: begin
						if (in_text(HEXDIG, ch)) begin
							grow();
							mode = stl_pkg::M_HEX;
						end else
							close_bad();
					end
					stl_pkg::M_HEX: begin
						if (in_text(HEXDIG, ch))
							grow();
						else begin
							close_as(stl_pkg::KIND_HEX);
							relex = 1'b1;
						end
					end
					stl_pkg::M_FF0: begin
						if (is_numeral(ch)) begin
							grow();
							mode = stl_pkg::M_FFA;
						end else
							close_bad();
					end
					stl_pkg::M_FFA: begin
						if (is_numeral(ch))
							grow();
						else if (ch == stl_pkg::CH_M) begin
							grow();
							mode = stl_pkg::M_FFM;
						end else
							close_bad();
					end
					stl_pkg::M_FFM: begin
						if (is_numeral(ch)) begin
							grow();
							mode = stl_pkg::M_FFB;
						end else
							close_bad();
					end
					stl_pkg::M_FFB: begin
						if (is_numeral(ch))
							grow();
						else begin
							close_as(stl_pkg::KIND_FIELD);
							relex = 1'b1;
						end
					end
					stl_pkg::M_INT: begin
						if (is_numeral(ch))
							grow();
						else if (ch == stl_pkg::CH_DOT) begin
							grow();
							mode = stl_pkg::M_DEC0;
						end else begin
							close_as(stl_pkg::KIND_INT);
							relex = 1'b1;
						end
					end
					stl_pkg::M_DEC0: begin
						if (is_numeral(ch)) begin
							grow();
							mode = stl_pkg::M_DEC;
						end else
							close_bad();
					end
					stl_pkg::M_DEC: begin
						if (is_numeral(ch))
							grow();
						else begin
							close_as(stl_pkg::KIND_DEC);
							relex = 1'b1;
						end
					end
					stl_pkg::M_COLON: begin
						if (in_text(SYM_FIRST, ch)) begin
							grow();
							mode = stl_pkg::M_KEYWORD;
						end else
							close_bad();
					end
					stl_pkg::M_KEYWORD: begin
						if (in_text(SYM_REST, ch))
							grow();
						else begin
							close_as(stl_pkg::KIND_KEYWORD);
							relex = 1'b1;
						end
					end
					stl_pkg::M_SYMBOL: begin
						if (in_text(SYM_REST, ch))
							grow();
						else begin
							close_as(stl_pkg::KIND_SYMBOL);
							relex = 1'b1;
						end
					end
					default: begin
						mode  = stl_pkg::M_IDLE;
						relex = 1'b1;
					end
				endcase
				if (relex)
					lex_start(ch);
				if (ch == stl_pkg::CH_LF) begin
					line_cnt = bump_pos(line_cnt);
					col_cnt  = '0;
				end else
					col_cnt = bump_pos(col_cnt);
			end
			if (fresh.size() > 0)
				fresh[fresh.size()-1].last = 1'b1;
			foreach (fresh[i])
				pending_tokens = {pending_tokens, fresh[i]};
		endfunction

		function void report(string what, logic [31:0] want, logic [31:0] got);
			mismatches++;
			if (mismatches <= MISMATCH_PRINTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		endfunction

		function void check_token(token_t got);
			token_t want;
			if (pending_tokens.size() == 0) begin
				mismatches++;
				if (mismatches <= MISMATCH_PRINTS)
					$display("%0t: unexpected token, expected none, actual kind %0d len %0d at %0d:%0d",
						$time, got.kind, got.len, got.line, got.col);
				return;
			end
			want = pending_tokens.pop_front();
			tokens_checked++;
			kinds_seen[want.kind] = 1'b1;
			if (got.kind !== want.kind) report("token_kind", want.kind, got.kind);
			if (got.len !== want.len)   report("token_length", want.len, got.len);
			if (got.line !== want.line) report("start_line", want.line, got.line);
			if (got.col !== want.col)   report("start_column", want.col, got.col);
			if (got.last !== want.last) report("last", want.last, got.last);
		endfunction

		function void finish_check();
			if (pending_tokens.size() != 0) begin
				$display("%0t: %0d expected tokens never arrived", $time, pending_tokens.size());
				mismatches += pending_tokens.size();
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	stl_in_if  chars_bus();
	stl_out_if tokens_bus();

	sexpr_token_lexer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_bus),
		.tokens (tokens_bus)
	);

	token_predictor lexer_model = new();

	bit          quiet      = 1'b0;
	bit          hold_req   = 1'b0;
	int unsigned words_sent = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] pick(string set);
		return set[$urandom_range(set.len() - 1)];
	endfunction

	task automatic put_word(logic [7:0] ch, logic eoi);
		while (!quiet && $urandom_range(99) < 28) begin
			chars_bus.valid <= 1'b0;
			@(posedge clk);
		end
		chars_bus.valid        <= 1'b1;
		chars_bus.char_byte    <= ch;
		chars_bus.end_of_input <= eoi;
		@(posedge clk);
		while (!chars_bus.ready)
			@(posedge clk);
		lexer_model.note_char(ch, eoi);
		words_sent++;
	endtask

	task automatic put_text(string s);
		for (int i = 0; i < s.len(); i++)
			put_word(s[i], 1'b0);
	endtask

	task automatic put_blank();
		if ($urandom_range(2) == 0)
			put_word(8'd32, 1'b0);
		else
			put_word(8'($urandom_range(13, 9)), 1'b0);
	endtask

	// One token of random shape, mostly well formed, then zero to two blanks.
	task automatic put_random_token();
		int         roll;
		int         n;
		logic [7:0] b;
		roll = $urandom_range(99);
		if (roll < 8)
			put_word(pick("()"), 1'b0);
		else if (roll < 12)
			put_word(pick("_!"), 1'b0);
		else if (roll < 20) begin
			put_word(stl_pkg::CH_COLON, 1'b0);
			put_word(pick(SYM_FIRST), 1'b0);
			repeat ($urandom_range(5)) put_word(pick(SYM_REST), 1'b0);
		end else if (roll < 32) begin
			put_word(pick(SYM_FIRST), 1'b0);
			repeat ($urandom_range(6)) put_word(pick(SYM_REST), 1'b0);
		end else if (roll < 40) begin
			put_word(stl_pkg::CH_BAR, 1'b0);
			repeat ($urandom_range(6)) begin
				b = 8'($urandom_range(255));
				put_word((b == stl_pkg::CH_BAR) ? 8'h61 : b, 1'b0);
			end
			put_word(stl_pkg::CH_BAR, 1'b0);
		end else if (roll < 48) begin
			put_word(stl_pkg::CH_QUOTE, 1'b0);
			repeat ($urandom_range(6)) begin
				if ($urandom_range(4) == 0)
					put_text("\"\"");
				else begin
					b = 8'($urandom_range(255));
					put_word((b == stl_pkg::CH_QUOTE) ? 8'h71 : b, 1'b0);
				end
			end
			put_word(stl_pkg::CH_QUOTE, 1'b0);
		end else if (roll < 56)
			repeat ($urandom_range(6, 1)) put_word(pick(DIGITS), 1'b0);
		else if (roll < 62) begin
			repeat ($urandom_range(3, 1)) put_word(pick(DIGITS), 1'b0);
			put_word(stl_pkg::CH_DOT, 1'b0);
			repeat ($urandom_range(3, 1)) put_word(pick(DIGITS), 1'b0);
		end else if (roll < 68) begin
			put_text("#b");
			repeat ($urandom_range(6, 1)) put_word(pick("01"), 1'b0);
		end else if (roll < 74) begin
			put_text("#x");
			repeat ($urandom_range(6, 1)) put_word(pick(HEXDIG), 1'b0);
		end else if (roll < 80) begin
			put_text("#f");
			repeat ($urandom_range(3, 1)) put_word(pick(DIGITS), 1'b0);
			put_word(stl_pkg::CH_M, 1'b0);
			repeat ($urandom_range(3, 1)) put_word(pick(DIGITS), 1'b0);
		end else if (roll < 84) begin
			put_word(stl_pkg::CH_SEMI, 1'b0);
			repeat ($urandom_range(6)) begin
				b = 8'($urandom_range(255));
				put_word((b == stl_pkg::CH_LF) ? 8'h20 : b, 1'b0);
			end
			put_word(stl_pkg::CH_LF, 1'b0);
		end else if (roll < 91)
			put_word(8'($urandom_range(255)), 1'b0);
		else if (roll < 97) begin
			// A literal or keyword prefix cut short by an arbitrary byte.
			n = $urandom_range(7);
			case (n)
				0: put_text("#");
				1: put_text("#b");
				2: put_text("#x");
				3: put_text("#f");
				4: put_text("#f1");
				5: put_text("#f1m");
				6: put_text("1.");
				default: put_text(":");
			endcase
			put_word(8'($urandom_range(255)), 1'b0);
		end else if (roll < 98) begin
			b = $urandom_range(1) ? stl_pkg::CH_BAR : stl_pkg::CH_QUOTE;
			put_word(b, 1'b0);
			repeat ($urandom_range(3)) put_word(pick(SYM_REST), 1'b0);
			put_word(8'($urandom_range(255)), 1'b1);
		end else
			put_word(8'($urandom_range(255)), 1'b1);
		repeat ($urandom_range(2)) put_blank();
	endtask

	task automatic wait_drained();
		while (lexer_model.pending_tokens.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: checks accepted tokens and drives ready.
	initial begin
		int     hold_left;
		token_t got;
		hold_left = 0;
		tokens_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (tokens_bus.valid && tokens_bus.ready) begin
				got.kind = stl_pkg::kind_t'(tokens_bus.token_kind);
				got.len  = tokens_bus.token_length;
				got.line = tokens_bus.start_line;
				got.col  = tokens_bus.start_column;
				got.last = tokens_bus.last;
				lexer_model.check_token(got);
			end
			if (hold_left > 0) begin
				hold_left--;
				tokens_bus.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
				tokens_bus.ready <= 1'b0;
			end else
				tokens_bus.ready <= quiet || ($urandom_range(99) >= 28);
		end
	end

	// Watchdog: ends the run when no word moves on either side for too long.
	initial begin
		int unsigned still;
		still = 0;
		while (still < STALL_LIMIT) begin
			@(posedge clk);
			if ((chars_bus.valid && chars_bus.ready) || (tokens_bus.valid && tokens_bus.ready))
				still = 0;
			else
				still++;
		end
		$display("%0t: no word accepted for %0d cycles", $time, still);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int unsigned random_start;
		arst_n                 <= 1'b0;
		chars_bus.valid        <= 1'b0;
		chars_bus.char_byte    <= 8'h00;
		chars_bus.end_of_input <= 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every token kind but the integer and the two unterminated ones, an escaped quote, a delimiter
		// that starts the next token, a bad byte inside a literal, bad start bytes at both ends of the
		// range, and end of input with a symbol still open.
		put_text("(_!:k a|q|\"\"\"\"9.5#b1#xF#f3m7)#z");
		put_word(8'h00, 1'b0);
		put_word(8'hFF, 1'b0);
		put_word(8'h78, 1'b0);
		put_word(8'hA5, 1'b1);

		random_start = words_sent;
		while (words_sent - random_start < RANDOM_WORDS) begin
			quiet = (words_sent - random_start >= 150) && (words_sent - random_start < 260);
			put_random_token();
		end
		quiet = 1'b0;

		// The output stalls for a long stretch while characters keep coming.
		hold_req = 1'b1;
		repeat (40) put_word(pick("()"), 1'b0);
		chars_bus.valid <= 1'b0;
		wait_drained();

		put_word(8'h00, 1'b1);
		chars_bus.valid <= 1'b0;

		wait_drained();
		repeat (20) @(posedge clk);
		lexer_model.finish_check();
		$display("Lexed %0d characters into %0d checked tokens, %0d of 17 token kinds seen,",
			words_sent, lexer_model.tokens_checked, $countones(lexer_model.kinds_seen));
		$display("with random gaps on both sides, a long output hold and a drain pause.");
		if (lexer_model.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sexpr_token_lexer.f =====
+incdir+src
src/stl_pkg.sv
src/stl_in_if.sv
src/stl_out_if.sv
src/stl_step.sv
src/stl_queue.sv
src/sexpr_token_lexer.sv
src/stl_checker.sv
tb/tb_top.sv
